// ----- rtl/rbs_pkg.sv -----
// Shared types, codes and interval tables for the reconnect backoff scheduler.
package rbs_pkg;

	// Widths of the item fields and configuration registers
	localparam int unsigned FUNC_W       = 2;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned JITTER_W     = 5;
	localparam int unsigned ACTION_W     = 2;
	localparam int unsigned WAIT_W       = 21;
	localparam int unsigned THRESHOLD_W  = 20;
	localparam int unsigned BUFFER_W     = 16;
	localparam int unsigned RISE_W       = 10;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 20;
	localparam int unsigned SALT_ADD_MS_W = 20;
	localparam int unsigned BACKOFF_IDX_MAX_W = 4;

	// Request types
	localparam logic [FUNC_W-1:0] FUNC_TASK      = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LONG_LINK = 2'd1;

	// Result actions
	localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CONNECT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WAIT    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_UP_DOWN_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INACTIVE_BUFFER   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_NET_RISE       = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_ACCOUNT_RISE   = 2'd3;

	// Configuration reset values
	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET  = 20'd600000;
	localparam logic [BUFFER_W-1:0]    BUFFER_RESET     = 16'd30000;
	localparam logic [RISE_W-1:0]      NO_NET_RISE_RESET  = 10'd600;
	localparam logic [RISE_W-1:0]      NO_ACCT_RISE_RESET = 10'd300;

	// Foreground age limits and scaling
	localparam logic [TIME_W-1:0] FG_ACTIVE_AGE_MS = 32'd600000;
	localparam logic [TIME_W-1:0] FG_TEN_AGE_MS    = 32'd60000;
	localparam int unsigned MS_PER_S = 1000;

	// Long link interval in the foreground-active class and its salted forms
	localparam int unsigned LL_FG_ACTIVE_S   = 240;
	localparam int unsigned NO_NET_SALT_RATE  = 3;
	localparam int unsigned NO_ACCT_SALT_RATE = 2;
	localparam logic [WAIT_W-1:0] LL_PLAIN_MS =
		WAIT_W'(LL_FG_ACTIVE_S * MS_PER_S);
	localparam logic [WAIT_W-1:0] LL_NO_NET_MS =
		WAIT_W'(LL_FG_ACTIVE_S * NO_NET_SALT_RATE * MS_PER_S);
	localparam logic [WAIT_W-1:0] LL_NO_ACCT_MS =
		WAIT_W'(LL_FG_ACTIVE_S * NO_ACCT_SALT_RATE * MS_PER_S);

	// Activity class
	typedef enum logic [2:0] {
		CLS_FG_ONE,
		CLS_FG_TEN,
		CLS_FG_ACTIVE,
		CLS_BG_ACTIVE,
		CLS_INACTIVE
	} cls_t;

	// Work kind handed from the front to the back
	typedef enum logic [1:0] {
		JOB_BUSY,
		JOB_INTERVAL,
		JOB_REBUILD,
		JOB_BACKOFF
	} job_kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic                link_busy;
		logic                is_active;
		logic                is_foreground;
		logic [TIME_W-1:0]   fg_age_ms;
		logic [TIME_W-1:0]   elapsed_ms;
		logic                no_network;
		logic                no_account;
		logic [JITTER_W-1:0] jitter_s;
		logic                rebuild_request;
	} in_item_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WAIT_W-1:0]   wait_ms;
	} out_item_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              inactive;
		logic [WAIT_W-1:0] iv_ms;
		logic [TIME_W-1:0] elapsed_ms;
	} job_t;

	typedef struct packed {
		logic [THRESHOLD_W-1:0] up_down_threshold_ms;
		logic [BUFFER_W-1:0]    inactive_buffer_ms;
		logic [RISE_W-1:0]      no_net_rise_s;
		logic [RISE_W-1:0]      no_account_rise_s;
	} cfg_t;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Base interval in ms by request type and activity class
	function automatic logic [WAIT_W-1:0] base_interval_ms(
		input logic [FUNC_W-1:0] func,
		input cls_t              cls
	);
		logic [WAIT_W-1:0] ms;
		ms = '0;
		case (func)
			FUNC_TASK: begin
				case (cls)
					CLS_FG_ONE:    ms = 21'd5000;
					CLS_FG_TEN:    ms = 21'd10000;
					CLS_FG_ACTIVE: ms = 21'd20000;
					CLS_BG_ACTIVE: ms = 21'd30000;
					default:       ms = 21'd300000;
				endcase
			end
			FUNC_LONG_LINK: begin
				case (cls)
					CLS_FG_ONE:    ms = 21'd15000;
					CLS_FG_TEN:    ms = 21'd30000;
					CLS_FG_ACTIVE: ms = LL_PLAIN_MS;
					CLS_BG_ACTIVE: ms = 21'd300000;
					default:       ms = 21'd600000;
				endcase
			end
			default: ms = '0;
		endcase
		return ms;
	endfunction

	// Backoff table in ms; indexes past the table use the last value
	function automatic logic [THRESHOLD_W-1:0] backoff_ms(
		input logic [BACKOFF_IDX_MAX_W-1:0] idx
	);
		logic [THRESHOLD_W-1:0] ms;
		case (idx)
			4'd0:    ms = 20'd0;
			4'd1:    ms = 20'd60000;
			4'd2:    ms = 20'd120000;
			4'd3:    ms = 20'd240000;
			4'd4:    ms = 20'd360000;
			4'd5:    ms = 20'd480000;
			default: ms = 20'd600000;
		endcase
		return ms;
	endfunction

endpackage

// ----- rtl/reconnect_backoff_scheduler.sv -----
// Reconnect backoff scheduler top level: config registers, front, queue and back.
// An accepted item passes the job queue, then the result register, to out_item.
// Throughput: one item and one decided job per cycle while out_stall is low.
// The two-entry job queue stalls the input only when the result side backs up.
// Reset clears the queue, the result valid and the backoff index, and loads the
// configuration defaults; no clearing pass is needed.
module reconnect_backoff_scheduler #(
	parameter int unsigned BACKOFF_STEPS = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rbs_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output rbs_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [rbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rbs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rbs_pkg::*;

	cfg_t cfg_q;
	job_t front_job;
	job_t head_job;
	logic head_valid;
	logic queue_full;
	logic pop;
	logic push;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_down_threshold_ms <= THRESHOLD_RESET;
			cfg_q.inactive_buffer_ms   <= BUFFER_RESET;
			cfg_q.no_net_rise_s        <= NO_NET_RISE_RESET;
			cfg_q.no_account_rise_s    <= NO_ACCT_RISE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UP_DOWN_THRESHOLD: cfg_q.up_down_threshold_ms <= cfg_wdata;
				CFG_INACTIVE_BUFFER:   cfg_q.inactive_buffer_ms <= cfg_wdata[BUFFER_W-1:0];
				CFG_NO_NET_RISE:       cfg_q.no_net_rise_s <= cfg_wdata[RISE_W-1:0];
				CFG_NO_ACCOUNT_RISE:   cfg_q.no_account_rise_s <= cfg_wdata[RISE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	rbs_front u_front (
		.in_item (in_item),
		.cfg     (cfg_q),
		.job     (front_job)
	);

	rbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (front_job),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid),
		.full       (queue_full)
	);

	rbs_back #(
		.BACKOFF_STEPS (BACKOFF_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_job   (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

// ----- rtl/rbs_front.sv -----
// Front end: classifies each request, picks its interval and job kind.
module rbs_front (
	input  rbs_pkg::in_item_t in_item,
	input  rbs_pkg::cfg_t     cfg,
	output rbs_pkg::job_t     job
);
	import rbs_pkg::*;

	cls_t                     cls;
	logic                     is_long_link;
	logic                     is_task;
	logic                     salted;
	logic [RISE_W-1:0]        add_s;
	logic [SALT_ADD_MS_W-1:0] add_ms;
	logic [WAIT_W-1:0]        base_ms;

	// Classify activity
	always_comb begin
		if (!in_item.is_active) begin
			cls = CLS_INACTIVE;
		end else if (!in_item.is_foreground) begin
			cls = CLS_BG_ACTIVE;
		end else if (in_item.fg_age_ms >= FG_ACTIVE_AGE_MS) begin
			cls = CLS_FG_ACTIVE;
		end else if (in_item.fg_age_ms >= FG_TEN_AGE_MS) begin
			cls = CLS_FG_TEN;
		end else begin
			cls = CLS_FG_ONE;
		end
	end

	assign is_long_link = (in_item.func == FUNC_LONG_LINK);
	assign is_task      = (in_item.func == FUNC_TASK);
	assign salted       = is_long_link && (cls == CLS_FG_ACTIVE);

	// Pick the base, salted or not, and the seconds to add on top of it
	always_comb begin
		if (!salted) begin
			base_ms = base_interval_ms(in_item.func, cls);
			add_s   = '0;
		end else if (in_item.no_network) begin
			base_ms = LL_NO_NET_MS;
			add_s   = cfg.no_net_rise_s;
		end else if (in_item.no_account) begin
			base_ms = LL_NO_ACCT_MS;
			add_s   = cfg.no_account_rise_s;
		end else begin
			base_ms = LL_PLAIN_MS;
			add_s   = RISE_W'(in_item.jitter_s);
		end
	end

	assign add_ms = SALT_ADD_MS_W'(add_s) * SALT_ADD_MS_W'(MS_PER_S);

	// Build the job for the back end
	always_comb begin
		job.inactive   = !in_item.is_active;
		job.iv_ms      = base_ms + WAIT_W'(add_ms);
		job.elapsed_ms = in_item.elapsed_ms;
		if (in_item.link_busy) begin
			job.kind = JOB_BUSY;
		end else if (in_item.is_active || (!is_long_link && !is_task)) begin
			job.kind = JOB_INTERVAL;
		end else if (in_item.rebuild_request) begin
			job.kind = JOB_REBUILD;
		end else begin
			job.kind = JOB_BACKOFF;
		end
	end

endmodule

// ----- rtl/rbs_queue.sv -----
// Short job queue between the front and back ends.
module rbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rbs_pkg::job_t  push_job,
	input  logic           pop,
	output rbs_pkg::job_t  head_job,
	output logic           head_valid,
	output logic           full
);
	import rbs_pkg::*;

	localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t               entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;

	assign head_job   = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == COUNT_W'(QUEUE_DEPTH));

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- rtl/rbs_back.sv -----
// Back end: carries out interval and backoff decisions into the result register.
module rbs_back #(
	parameter int unsigned BACKOFF_STEPS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rbs_pkg::cfg_t      cfg,
	input  rbs_pkg::job_t      head_job,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output rbs_pkg::out_item_t out_item
);
	import rbs_pkg::*;

	localparam int unsigned IDX_W = $clog2(BACKOFF_STEPS);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(BACKOFF_STEPS - 1);

	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       idx_next;
	logic                   out_valid_q;
	out_item_t              out_q;
	out_item_t              result;
	logic [TIME_W:0]        reach_ms;
	logic [THRESHOLD_W-1:0] table_ms;
	logic [THRESHOLD_W-1:0] remain_ms;
	logic [THRESHOLD_W-1:0] clamp_ms;
	logic                   rising;

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Step the backoff index up or down, saturating at both ends
	assign rising = (head_job.elapsed_ms < TIME_W'(cfg.up_down_threshold_ms));
	always_comb begin
		idx_next = idx_q;
		if (rising) begin
			if (idx_q < IDX_TOP) begin
				idx_next = idx_q + 1'b1;
			end
		end else if (idx_q != '0) begin
			idx_next = idx_q - 1'b1;
		end
	end

	// Backoff wait: table value less elapsed time, clamped to the threshold
	assign table_ms  = backoff_ms(BACKOFF_IDX_MAX_W'(idx_next));
	assign remain_ms = (head_job.elapsed_ms >= TIME_W'(table_ms)) ? '0 :
		table_ms - head_job.elapsed_ms[THRESHOLD_W-1:0];
	assign clamp_ms  = (remain_ms > cfg.up_down_threshold_ms) ?
		cfg.up_down_threshold_ms : remain_ms;

	// Interval reach: elapsed time plus the inactive buffer
	assign reach_ms = {1'b0, head_job.elapsed_ms} +
		((head_job.inactive) ? (TIME_W + 1)'(cfg.inactive_buffer_ms) : '0);

	// Decide the result
	always_comb begin
		result.action  = ACT_CONNECT;
		result.wait_ms = '0;
		case (head_job.kind)
			JOB_BUSY: begin
				result.action = ACT_NONE;
			end
			JOB_INTERVAL: begin
				if (reach_ms < (TIME_W + 1)'(head_job.iv_ms)) begin
					result.action  = ACT_WAIT;
					result.wait_ms = head_job.iv_ms - head_job.elapsed_ms[WAIT_W-1:0];
				end
			end
			JOB_BACKOFF: begin
				if (clamp_ms != '0) begin
					result.action  = ACT_WAIT;
					result.wait_ms = WAIT_W'(clamp_ms);
				end
			end
			default: begin
				result.action = ACT_CONNECT;
			end
		endcase
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= result;
		end
	end

	// Hold result valid and backoff index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && (head_job.kind == JOB_BACKOFF)) begin
				idx_q <= idx_next;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_TOP)
		else $error("backoff index beyond table");

	a_idx_only_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && (head_job.kind == JOB_BACKOFF)) |=> $stable(idx_q))
		else $error("backoff index moved without a backoff item");

	a_wait_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.action == ACT_WAIT)) |-> (out_q.wait_ms != '0))
		else $error("wait result with zero delay");

	a_busy_none: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (head_job.kind == JOB_BUSY)) |=>
		(out_q.action == ACT_NONE) && (out_q.wait_ms == '0))
		else $error("busy item gave an action");

endmodule
